/* rtl/core/sscs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscs_pkg - shared types and constants of the sorted sparse cell store
// Sizes, operation and status codes, entry layout, FSM states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sscs_pkg;

  localparam int INDEX_BITS  = 18;
  localparam int MAX_ENTRIES = 256;
  localparam int CELL_W      = 18;
  localparam int MAT_W       = 8;
  localparam int FUNC_W      = 2;
  localparam int STAT_W      = 2;
  localparam int TOTAL_W     = 9;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_GET    = 2'd0,
    FN_SET    = 2'd1,
    FN_REMOVE = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    RS_OK     = 2'd0,
    RS_ABSENT = 2'd1,
    RS_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] cidx;
    logic [MAT_W-1:0]      mat;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_PROBE,
    S_SH_RD,
    S_SH_WR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic    idle;
    logic    load_req;
    logic    rd_mid;
    logic    step;
    logic    rd_lo;
    logic    rd_shift;
    logic    wr_shift;
    logic    wr_pos;
    logic    init_ins;
    logic    init_rem;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_res;
    status_t res_status;
    logic    res_hit_mat;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic              search_open;
    logic              hit;
    logic              full;
    logic              shift_more;
    logic              out_free;
    logic [FUNC_W-1:0] func;
  } dp_sts_t;

endpackage

/* rtl/core/sscs_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscs_dp - datapath of the sorted sparse cell store
// Entry memory, search bounds, shift pointer, entry count, result and
// output registers.
// ----------------------------------------------------------------------------
module sscs_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sscs_pkg::ctrl_cmd_t            cmd,
  output sscs_pkg::dp_sts_t              sts,
  input  logic [sscs_pkg::FUNC_W-1:0]    in_func,
  input  logic [sscs_pkg::CELL_W-1:0]    in_cell_index,
  input  logic [sscs_pkg::MAT_W-1:0]     in_material_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sscs_pkg::STAT_W-1:0]    out_status,
  output logic [sscs_pkg::MAT_W-1:0]     out_material_out,
  output logic [sscs_pkg::TOTAL_W-1:0]   out_entry_total
);

  sscs_pkg::entry_t mem [sscs_pkg::MAX_ENTRIES];
  sscs_pkg::entry_t rd_data_r;

  logic [sscs_pkg::FUNC_W-1:0]     func_r;
  logic [sscs_pkg::INDEX_BITS-1:0] cell_r;
  logic [sscs_pkg::MAT_W-1:0]      mat_r;
  logic [sscs_pkg::CNT_W-1:0]      lo_r, hi_r, ptr_r, count_r;
  sscs_pkg::status_t               res_status_r;
  logic [sscs_pkg::MAT_W-1:0]      res_mat_r;

  logic                            out_valid_r;
  logic [sscs_pkg::STAT_W-1:0]     out_status_r;
  logic [sscs_pkg::MAT_W-1:0]      out_mat_r;
  logic [sscs_pkg::TOTAL_W-1:0]    out_total_r;

  logic [sscs_pkg::CNT_W:0]        bound_sum;
  logic [sscs_pkg::CNT_W-1:0]      mid, mid_p1, ptr_m1, ptr_p1;
  logic                            ins_mode;
  logic                            rd_en, wr_en;
  logic [sscs_pkg::ADDR_W-1:0]     rd_addr, wr_addr;
  sscs_pkg::entry_t                wr_data;

  assign bound_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = bound_sum[sscs_pkg::CNT_W:1];
  assign mid_p1    = mid + 1'b1;
  assign ptr_m1    = ptr_r - 1'b1;
  assign ptr_p1    = ptr_r + 1'b1;
  assign ins_mode  = (func_r == sscs_pkg::FN_SET);

  always_comb begin
    rd_en   = cmd.rd_mid | cmd.rd_lo | cmd.rd_shift;
    rd_addr = lo_r[sscs_pkg::ADDR_W-1:0];
    if (cmd.rd_mid) begin
      rd_addr = mid[sscs_pkg::ADDR_W-1:0];
    end else if (cmd.rd_shift) begin
      rd_addr = ins_mode ? ptr_m1[sscs_pkg::ADDR_W-1:0] : ptr_p1[sscs_pkg::ADDR_W-1:0];
    end
    wr_en   = cmd.wr_shift | cmd.wr_pos;
    wr_addr = cmd.wr_pos ? lo_r[sscs_pkg::ADDR_W-1:0] : ptr_r[sscs_pkg::ADDR_W-1:0];
    wr_data = rd_data_r;
    if (cmd.wr_pos) begin
      wr_data.cidx = cell_r;
      wr_data.mat  = mat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // request and working registers (no reset needed)
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func_r <= in_func;
      cell_r <= in_cell_index[sscs_pkg::INDEX_BITS-1:0];
      mat_r  <= in_material_in;
      lo_r   <= '0;
      hi_r   <= count_r;
    end
    if (cmd.step) begin
      if (rd_data_r.cidx < cell_r) begin
        lo_r <= mid_p1;
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.init_ins) begin
      ptr_r <= count_r;
    end else if (cmd.init_rem) begin
      ptr_r <= lo_r;
    end else if (cmd.wr_shift) begin
      ptr_r <= ins_mode ? ptr_m1 : ptr_p1;
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_mat_r    <= cmd.res_hit_mat ? rd_data_r.mat : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_mat_r    <= res_mat_r;
      out_total_r  <= sscs_pkg::TOTAL_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.search_open = (lo_r < hi_r);
    sts.hit         = (lo_r < count_r) && (rd_data_r.cidx == cell_r);
    sts.full        = (count_r == sscs_pkg::CNT_W'(sscs_pkg::MAX_ENTRIES));
    sts.shift_more  = ins_mode ? (ptr_r > lo_r) : (ptr_p1 < count_r);
    sts.out_free    = !out_valid_r || !out_stall;
    sts.func        = func_r;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_material_out = out_mat_r;
  assign out_entry_total  = out_total_r;

endmodule

/* rtl/core/sscs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscs_ctrl - sequencer of the sorted sparse cell store
// Runs search, probe, shift and result handoff for one request at a time.
// ----------------------------------------------------------------------------
module sscs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  sscs_pkg::dp_sts_t   sts,
  output sscs_pkg::ctrl_cmd_t cmd
);

  sscs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sscs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      sscs_pkg::S_IDLE: begin
        cmd.idle = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = sscs_pkg::S_SRCH;
        end
      end
      sscs_pkg::S_SRCH: begin
        if (sts.search_open) begin
          cmd.rd_mid = 1'b1;
          state_nxt  = sscs_pkg::S_CMP;
        end else begin
          cmd.rd_lo = 1'b1;
          state_nxt = sscs_pkg::S_PROBE;
        end
      end
      sscs_pkg::S_CMP: begin
        cmd.step  = 1'b1;
        state_nxt = sscs_pkg::S_SRCH;
      end
      sscs_pkg::S_PROBE: begin
        cmd.set_res    = 1'b1;
        cmd.res_status = sscs_pkg::RS_OK;
        state_nxt      = sscs_pkg::S_FIN;
        case (sts.func)
          sscs_pkg::FN_GET: begin
            if (sts.hit) begin
              cmd.res_hit_mat = 1'b1;
            end else begin
              cmd.res_status = sscs_pkg::RS_ABSENT;
            end
          end
          sscs_pkg::FN_SET: begin
            if (sts.hit) begin
              cmd.wr_pos = 1'b1;
            end else if (sts.full) begin
              cmd.res_status = sscs_pkg::RS_FULL;
            end else begin
              cmd.init_ins = 1'b1;
              state_nxt    = sscs_pkg::S_SH_RD;
            end
          end
          sscs_pkg::FN_REMOVE: begin
            if (sts.hit) begin
              cmd.init_rem = 1'b1;
              state_nxt    = sscs_pkg::S_SH_RD;
            end else begin
              cmd.res_status = sscs_pkg::RS_ABSENT;
            end
          end
          default: begin
          end
        endcase
      end
      sscs_pkg::S_SH_RD: begin
        if (sts.shift_more) begin
          cmd.rd_shift = 1'b1;
          state_nxt    = sscs_pkg::S_SH_WR;
        end else begin
          // gap is open (insert) or closed (remove)
          if (sts.func == sscs_pkg::FN_SET) begin
            cmd.wr_pos  = 1'b1;
            cmd.cnt_inc = 1'b1;
          end else begin
            cmd.cnt_dec = 1'b1;
          end
          state_nxt = sscs_pkg::S_FIN;
        end
      end
      sscs_pkg::S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = sscs_pkg::S_SH_RD;
      end
      sscs_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sscs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sscs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/sorted_sparse_cell_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_sparse_cell_store - sorted override table for one volume chunk
// Get, set and remove of (cell index, material) entries kept in ascending
// cell order, located by a lower-bound binary search.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request is loaded, then each binary-search
// step reads the middle entry and then compares (9 steps at most for 256
// entries); the lower-bound entry is then read and probed, and the result is
// handed to the output register. That ends a get, an overwrite, a miss or a
// full refusal. An insert moves every entry from its position upward up by
// one slot and a remove moves every entry above the removed one down by one
// slot, reading and then writing each entry in turn through the entry memory,
// and a closing step writes the new entry or updates the count.
// The result waits in its own register, so the next request is taken while
// the previous result is still stalled; the block only holds off a finishing
// request while that register is occupied. Entries are undefined after reset;
// the entry count starts at zero, so no clearing pass runs.
module sorted_sparse_cell_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sscs_pkg::FUNC_W-1:0]    in_func,
  input  logic [sscs_pkg::CELL_W-1:0]    in_cell_index,
  input  logic [sscs_pkg::MAT_W-1:0]     in_material_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sscs_pkg::STAT_W-1:0]    out_status,
  output logic [sscs_pkg::MAT_W-1:0]     out_material_out,
  output logic [sscs_pkg::TOTAL_W-1:0]   out_entry_total
);

  sscs_pkg::ctrl_cmd_t cmd;
  sscs_pkg::dp_sts_t   sts;

  // sequencer: search / probe / shift / handoff
  sscs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  // entry memory, bounds, count and output register
  sscs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_cell_index    (in_cell_index),
    .in_material_in   (in_material_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_material_out (out_material_out),
    .out_entry_total  (out_entry_total)
  );

  // new requests only enter while the sequencer is idle
  assign in_stall = !cmd.idle;

  // one request in flight: an accepted request blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another was in flight");

  // count never exceeds capacity
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_total <= sscs_pkg::TOTAL_W'(sscs_pkg::MAX_ENTRIES)))
    else $error("entry total above capacity");

  // a full refusal only happens at capacity
  a_full_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == sscs_pkg::RS_FULL)) |->
    (out_entry_total == sscs_pkg::TOTAL_W'(sscs_pkg::MAX_ENTRIES)))
    else $error("full status below capacity");

  // material is only reported on a successful lookup
  a_mat_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_material_out != '0)) |-> (out_status == sscs_pkg::RS_OK))
    else $error("material reported on a miss");

endmodule
